### src/silu_li_pkg.sv
package silu_li_pkg;

  // table geometry
  localparam int TABLE_BITS = 8;
  localparam int LEVELS     = 1 << TABLE_BITS;
  localparam int FRAC_BITS  = 12;

  // field widths
  localparam int X_W        = 16;
  localparam int RANGE_W    = 15;
  localparam int STEP_W     = 24;
  localparam int ENTRY_IDX_W = 8;
  localparam int U_W        = 16;
  localparam int PROD_W     = U_W + STEP_W;
  localparam int POS_W      = PROD_W - FRAC_BITS;
  localparam int IPART_W    = POS_W - FRAC_BITS;
  localparam int DIFF_W     = X_W + 1;
  localparam int MUL_W      = DIFF_W + POS_W + 1;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_X_RANGE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POS_SCALE = CFG_IDX_W'(1);

  localparam logic [RANGE_W-1:0] X_RANGE_RST   = RANGE_W'(16384);
  localparam logic [STEP_W-1:0]  POS_SCALE_RST = STEP_W'(130560);

  // request codes
  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [IPART_W-1:0] IDX_MAX = IPART_W'(LEVELS - 2);

  localparam logic signed [MUL_W-1:0] Y_MAX_W = MUL_W'(32767);
  localparam logic signed [MUL_W-1:0] Y_MIN_W = -MUL_W'(32768);

  typedef logic [TABLE_BITS-1:0] slot_t;
  typedef logic signed [X_W-1:0] sample_t;
  typedef logic [POS_W-1:0]      frac_t;

  typedef struct packed {
    logic valid;
    logic load;
  } ctl_t;

endpackage

### src/silu_li_if.sv
interface silu_li_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    req_type;
  logic signed [silu_li_pkg::X_W-1:0]      x_value;
  logic [silu_li_pkg::ENTRY_IDX_W-1:0]     entry_index;
  logic signed [silu_li_pkg::X_W-1:0]      entry_value;

  modport source (output valid, req_type, x_value, entry_index, entry_value, input ready);
  modport sink   (input valid, req_type, x_value, entry_index, entry_value, output ready);
endinterface

interface silu_li_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [silu_li_pkg::X_W-1:0]  y_value;

  modport source (output valid, y_value, input ready);
  modport sink   (input valid, y_value, output ready);
endinterface

interface silu_li_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [silu_li_pkg::CFG_IDX_W-1:0]      index;
  logic [silu_li_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/silu_lut_interpolator_top.sv
// SiLU by table lookup with linear interpolation, signed Q4.12 in and out.
// Two kinds of input beat: a load (req_type = 1) writes entry_value into slot
// entry_index (wrapped to the 256-entry table) and gives no result; an
// evaluate (req_type = 0) clamps x_value to +-x_range, scales (x + x_range) by
// pos_scale (Q12.12, table points per input unit) into a table position, and
// returns t[i] + floor((t[i+1] - t[i]) * frac / 4096), saturated to 16 bits.
// The index is held at 254 and the fraction may then pass one, so
// inconsistent settings extrapolate along the last segment. Throughput is one
// beat per clock when the pipeline is not stalled; an evaluate passes through
// the registers clamp, scale multiply, index split, table read, slope, slope
// multiply and sum/saturate into the output register. The whole pipeline
// stalls only while a result waits on out_if. The table has no reset and no
// clearing pass: evaluate only over entries already loaded. x_range (index 0)
// and pos_scale (index 1) are written through cfg_if; the user must write them
// only while no evaluate is in flight, as the block does not enforce this.
module silu_lut_interpolator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  silu_li_in_if.sink           in_if,
  silu_li_out_if.source        out_if,
  silu_li_cfg_if.sink          cfg_if
);

  // configuration registers
  logic [silu_li_pkg::RANGE_W-1:0] x_range_r;
  logic [silu_li_pkg::RANGE_W-1:0] x_range_nxt;
  logic [silu_li_pkg::STEP_W-1:0]  pos_scale_r;
  logic [silu_li_pkg::STEP_W-1:0]  pos_scale_nxt;

  // pipeline advance: everything moves unless a result is held
  logic                 adv;
  logic                 out_valid;
  silu_li_pkg::ctl_t    c_ctl;
  silu_li_pkg::slot_t   c_idx;
  silu_li_pkg::frac_t   c_frac;
  silu_li_pkg::slot_t   c_slot;
  silu_li_pkg::sample_t c_data;
  logic                 d_valid;
  silu_li_pkg::sample_t d_t0;
  silu_li_pkg::sample_t d_t1;
  silu_li_pkg::frac_t   d_frac;

  assign adv          = !out_valid || out_if.ready;
  assign in_if.ready  = adv;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid;

  always_comb begin
    x_range_nxt   = x_range_r;
    pos_scale_nxt = pos_scale_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        silu_li_pkg::CFG_X_RANGE: begin
          x_range_nxt = cfg_if.data[silu_li_pkg::RANGE_W-1:0];
        end
        silu_li_pkg::CFG_POS_SCALE: begin
          pos_scale_nxt = cfg_if.data[silu_li_pkg::STEP_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_range_r   <= silu_li_pkg::X_RANGE_RST;
      pos_scale_r <= silu_li_pkg::POS_SCALE_RST;
    end else begin
      x_range_r   <= x_range_nxt;
      pos_scale_r <= pos_scale_nxt;
    end
  end

  // stages A..C: clamp, scale, index/fraction
  silu_li_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_if.valid),
    .req_type    (in_if.req_type),
    .x_value     (in_if.x_value),
    .entry_index (in_if.entry_index),
    .entry_value (in_if.entry_value),
    .x_range     (x_range_r),
    .pos_scale   (pos_scale_r),
    .ctl_o       (c_ctl),
    .idx_o       (c_idx),
    .frac_o      (c_frac),
    .slot_o      (c_slot),
    .data_o      (c_data)
  );

  // stage D: table write for loads, paired read for evaluates
  silu_li_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_i   (c_ctl),
    .idx_i   (c_idx),
    .frac_i  (c_frac),
    .slot_i  (c_slot),
    .data_i  (c_data),
    .valid_o (d_valid),
    .t0_o    (d_t0),
    .t1_o    (d_t1),
    .frac_o  (d_frac)
  );

  // stages E, F and output register
  silu_li_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_i   (d_valid),
    .t0_i      (d_t0),
    .t1_i      (d_t1),
    .frac_i    (d_frac),
    .out_valid (out_valid),
    .y_value   (out_if.y_value)
  );

endmodule

### src/silu_li_front.sv
// clamp, scale by pos_scale, split position into index and fraction
module silu_li_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic                                req_type,
  input  logic signed [silu_li_pkg::X_W-1:0]  x_value,
  input  logic [silu_li_pkg::ENTRY_IDX_W-1:0] entry_index,
  input  logic signed [silu_li_pkg::X_W-1:0]  entry_value,
  input  logic [silu_li_pkg::RANGE_W-1:0]     x_range,
  input  logic [silu_li_pkg::STEP_W-1:0]      pos_scale,
  output silu_li_pkg::ctl_t                   ctl_o,
  output silu_li_pkg::slot_t                  idx_o,
  output silu_li_pkg::frac_t                  frac_o,
  output silu_li_pkg::slot_t                  slot_o,
  output silu_li_pkg::sample_t                data_o
);

  // stage A: clamped, offset input
  silu_li_pkg::ctl_t                   a_ctl_r;
  logic [silu_li_pkg::U_W-1:0]         a_u_r;
  silu_li_pkg::slot_t                  a_slot_r;
  silu_li_pkg::sample_t                a_data_r;
  // stage B: position
  silu_li_pkg::ctl_t                   b_ctl_r;
  logic [silu_li_pkg::POS_W-1:0]       b_pos_r;
  silu_li_pkg::slot_t                  b_slot_r;
  silu_li_pkg::sample_t                b_data_r;
  // stage C: index and fraction
  silu_li_pkg::ctl_t                   c_ctl_r;
  silu_li_pkg::slot_t                  c_idx_r;
  silu_li_pkg::frac_t                  c_frac_r;
  silu_li_pkg::slot_t                  c_slot_r;
  silu_li_pkg::sample_t                c_data_r;

  logic signed [silu_li_pkg::X_W:0]    x_ext;
  logic signed [silu_li_pkg::X_W:0]    r_ext;
  logic signed [silu_li_pkg::X_W:0]    x_clamp;
  logic signed [silu_li_pkg::X_W:0]    u_sum;
  silu_li_pkg::ctl_t                   a_ctl_nxt;
  logic [silu_li_pkg::PROD_W-1:0]      prod;
  logic [silu_li_pkg::IPART_W-1:0]     ipart;
  logic [silu_li_pkg::IPART_W-1:0]     idx_w;
  silu_li_pkg::frac_t                  frac_nxt;

  always_comb begin
    x_ext = {x_value[silu_li_pkg::X_W-1], x_value};
    r_ext = $signed({2'b00, x_range});
    priority if (x_ext < -r_ext) begin
      x_clamp = -r_ext;
    end else if (x_ext > r_ext) begin
      x_clamp = r_ext;
    end else begin
      x_clamp = x_ext;
    end
    u_sum = x_clamp + r_ext;
    a_ctl_nxt.valid = in_valid;
    a_ctl_nxt.load  = (req_type == silu_li_pkg::REQ_LOAD);
  end

  assign prod = silu_li_pkg::PROD_W'(a_u_r) * silu_li_pkg::PROD_W'(pos_scale);

  always_comb begin
    ipart    = b_pos_r[silu_li_pkg::POS_W-1:silu_li_pkg::FRAC_BITS];
    idx_w    = (ipart > silu_li_pkg::IDX_MAX) ? silu_li_pkg::IDX_MAX : ipart;
    frac_nxt = b_pos_r - {idx_w, {silu_li_pkg::FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
    end else if (adv) begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= a_ctl_r;
      c_ctl_r <= b_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_u_r    <= u_sum[silu_li_pkg::U_W-1:0];
      a_slot_r <= silu_li_pkg::slot_t'(entry_index);
      a_data_r <= entry_value;
      b_pos_r  <= prod[silu_li_pkg::PROD_W-1:silu_li_pkg::FRAC_BITS];
      b_slot_r <= a_slot_r;
      b_data_r <= a_data_r;
      c_idx_r  <= idx_w[silu_li_pkg::TABLE_BITS-1:0];
      c_frac_r <= frac_nxt;
      c_slot_r <= b_slot_r;
      c_data_r <= b_data_r;
    end
  end

  assign ctl_o  = c_ctl_r;
  assign idx_o  = c_idx_r;
  assign frac_o = c_frac_r;
  assign slot_o = c_slot_r;
  assign data_o = c_data_r;

  // offset input never exceeds twice the range
  a_u_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_ctl_r.valid && !a_ctl_r.load) |-> (a_u_r <= {x_range, 1'b0}))
    else $error("offset input beyond 2*x_range");

  // fraction only reaches one or more on the clamped top segment
  c_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (c_ctl_r.valid && !c_ctl_r.load &&
     (c_idx_r != silu_li_pkg::IDX_MAX[silu_li_pkg::TABLE_BITS-1:0]))
    |-> (c_frac_r < (silu_li_pkg::frac_t'(1) << silu_li_pkg::FRAC_BITS)))
    else $error("fraction of one or more below top segment");

endmodule

### src/silu_li_table.sv
// sample memory: one write port, two registered read ports
module silu_li_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  silu_li_pkg::ctl_t    ctl_i,
  input  silu_li_pkg::slot_t   idx_i,
  input  silu_li_pkg::frac_t   frac_i,
  input  silu_li_pkg::slot_t   slot_i,
  input  silu_li_pkg::sample_t data_i,
  output logic                 valid_o,
  output silu_li_pkg::sample_t t0_o,
  output silu_li_pkg::sample_t t1_o,
  output silu_li_pkg::frac_t   frac_o
);

  silu_li_pkg::sample_t mem [silu_li_pkg::LEVELS];
  logic                 d_valid_r;
  silu_li_pkg::sample_t d_t0_r;
  silu_li_pkg::sample_t d_t1_r;
  silu_li_pkg::frac_t   d_frac_r;
  silu_li_pkg::slot_t   idx_hi;

  assign idx_hi = silu_li_pkg::slot_t'(idx_i + 1'b1);

  // loads write at the same stage where evaluates read, so order is kept
  always_ff @(posedge clk) begin
    if (adv && ctl_i.valid && ctl_i.load) begin
      mem[slot_i] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_t0_r   <= mem[idx_i];
      d_t1_r   <= mem[idx_hi];
      d_frac_r <= frac_i;
    end
  end

  // loads end here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r <= ctl_i.valid && !ctl_i.load;
    end
  end

  assign valid_o = d_valid_r;
  assign t0_o    = d_t0_r;
  assign t1_o    = d_t1_r;
  assign frac_o  = d_frac_r;

endmodule

### src/silu_li_blend.sv
// interpolate between samples, floor shift, saturate, output register
module silu_li_blend (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                valid_i,
  input  silu_li_pkg::sample_t                t0_i,
  input  silu_li_pkg::sample_t                t1_i,
  input  silu_li_pkg::frac_t                  frac_i,
  output logic                                out_valid,
  output logic signed [silu_li_pkg::X_W-1:0]  y_value
);

  // stage E: slope
  logic                                    e_valid_r;
  logic signed [silu_li_pkg::DIFF_W-1:0]   e_diff_r;
  silu_li_pkg::sample_t                    e_t0_r;
  silu_li_pkg::frac_t                      e_frac_r;
  // stage F: product
  logic                                    f_valid_r;
  logic signed [silu_li_pkg::MUL_W-1:0]    f_prod_r;
  silu_li_pkg::sample_t                    f_t0_r;
  // result
  logic                                    out_valid_r;
  silu_li_pkg::sample_t                    y_r;

  logic signed [silu_li_pkg::DIFF_W-1:0]   diff_nxt;
  logic signed [silu_li_pkg::MUL_W-1:0]    prod_nxt;
  logic signed [silu_li_pkg::MUL_W-1:0]    shifted;
  logic signed [silu_li_pkg::MUL_W-1:0]    sum;
  silu_li_pkg::sample_t                    y_nxt;

  always_comb begin
    diff_nxt = $signed({t1_i[silu_li_pkg::X_W-1], t1_i})
             - $signed({t0_i[silu_li_pkg::X_W-1], t0_i});
    prod_nxt = e_diff_r * $signed({1'b0, e_frac_r});
    shifted  = f_prod_r >>> silu_li_pkg::FRAC_BITS;
    sum      = shifted + silu_li_pkg::MUL_W'(f_t0_r);
    priority if (sum > silu_li_pkg::Y_MAX_W) begin
      y_nxt = silu_li_pkg::Y_MAX_W[silu_li_pkg::X_W-1:0];
    end else if (sum < silu_li_pkg::Y_MIN_W) begin
      y_nxt = silu_li_pkg::Y_MIN_W[silu_li_pkg::X_W-1:0];
    end else begin
      y_nxt = sum[silu_li_pkg::X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r   <= valid_i;
      f_valid_r   <= e_valid_r;
      out_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_diff_r <= diff_nxt;
      e_t0_r   <= t0_i;
      e_frac_r <= frac_i;
      f_prod_r <= prod_nxt;
      f_t0_r   <= e_t0_r;
      y_r      <= y_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign y_value   = y_r;

  // a new result only follows an evaluate in the last stage
  out_from_f: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(f_valid_r))
    else $error("result beat without a preceding evaluate");

endmodule

### sim/silu_lut_interpolator_top_test.sv
module silu_lut_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver hold-off length and the no-progress limit.
  // The limit sits well above the hold-off, so a healthy run never trips it.
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 16;   // pipeline is 7 deep; a little margin
  localparam int PHASE_ITEMS    = 40;

  // Tracks the sample table and the two registers, and predicts each
  // evaluate's y_value. Expected results queue up in beat order.
  class silu_result_tracker;
    silu_li_pkg::sample_t            curve [silu_li_pkg::LEVELS];
    logic [silu_li_pkg::RANGE_W-1:0] range_q;
    logic [silu_li_pkg::STEP_W-1:0]  step_q;
    silu_li_pkg::sample_t            y_due [$];
    int                              errors;
    int                              checked;
    int                              loads;
    int                              evals;

    function new();
      range_q = silu_li_pkg::X_RANGE_RST;
      step_q  = silu_li_pkg::POS_SCALE_RST;
      errors  = 0;
      checked = 0;
      loads   = 0;
      evals   = 0;
    endfunction

    function void set_reg(logic [silu_li_pkg::CFG_IDX_W-1:0] idx,
                          logic [silu_li_pkg::CFG_DATA_W-1:0] data);
      if (idx == silu_li_pkg::CFG_X_RANGE)
        range_q = data[silu_li_pkg::RANGE_W-1:0];
      else if (idx == silu_li_pkg::CFG_POS_SCALE)
        step_q = data[silu_li_pkg::STEP_W-1:0];
    endfunction

    // Clamp, scale to a table position, split index/fraction, interpolate
    // along the segment with a floor shift, then saturate to 16 bits.
    function silu_li_pkg::sample_t silu_interp(silu_li_pkg::sample_t x);
      logic signed [silu_li_pkg::X_W:0]       xc;
      logic signed [silu_li_pkg::X_W:0]       r;
      logic [silu_li_pkg::U_W-1:0]            u;
      logic [silu_li_pkg::PROD_W-1:0]         prod;
      logic [silu_li_pkg::POS_W-1:0]          pos;
      logic [silu_li_pkg::IPART_W-1:0]        ipart;
      silu_li_pkg::frac_t                     frac;
      silu_li_pkg::slot_t                     lo;
      silu_li_pkg::sample_t                   t0;
      silu_li_pkg::sample_t                   t1;
      logic signed [silu_li_pkg::DIFF_W-1:0]  slope;
      logic signed [silu_li_pkg::MUL_W-1:0]   acc;
      xc = x;
      r  = range_q;
      if (xc < -r)
        xc = -r;
      else if (xc > r)
        xc = r;
      u     = silu_li_pkg::U_W'(xc + r);
      prod  = silu_li_pkg::PROD_W'(u) * silu_li_pkg::PROD_W'(step_q);
      pos   = prod[silu_li_pkg::PROD_W-1:silu_li_pkg::FRAC_BITS];
      ipart = pos[silu_li_pkg::POS_W-1:silu_li_pkg::FRAC_BITS];
      if (ipart > silu_li_pkg::IDX_MAX)
        ipart = silu_li_pkg::IDX_MAX;
      // past the top segment the fraction may reach or exceed one
      frac  = pos - (silu_li_pkg::POS_W'(ipart) << silu_li_pkg::FRAC_BITS);
      lo    = ipart[silu_li_pkg::TABLE_BITS-1:0];
      t0    = curve[lo];
      t1    = curve[lo + 1'b1];
      slope = silu_li_pkg::DIFF_W'(t1) - silu_li_pkg::DIFF_W'(t0);
      acc   = silu_li_pkg::MUL_W'(slope) * $signed({1'b0, frac});
      acc   = (acc >>> silu_li_pkg::FRAC_BITS) + silu_li_pkg::MUL_W'(t0);
      if (acc > silu_li_pkg::Y_MAX_W)
        acc = silu_li_pkg::Y_MAX_W;
      else if (acc < silu_li_pkg::Y_MIN_W)
        acc = silu_li_pkg::Y_MIN_W;
      return acc[silu_li_pkg::X_W-1:0];
    endfunction

    function void take_input(logic kind, silu_li_pkg::sample_t x,
                             logic [silu_li_pkg::ENTRY_IDX_W-1:0] slot,
                             silu_li_pkg::sample_t val);
      if (kind == silu_li_pkg::REQ_LOAD) begin
        curve[slot[silu_li_pkg::TABLE_BITS-1:0]] = val;
        loads++;
      end else begin
        y_due.push_back(silu_interp(x));
        evals++;
      end
    endfunction

    function void match_output(silu_li_pkg::sample_t y);
      silu_li_pkg::sample_t want;
      if (y_due.size() == 0) begin
        $display("%0t: y_value mismatch, expected none, got %0d", $time, y);
        errors++;
      end else begin
        want = y_due.pop_front();
        checked++;
        if (want !== y) begin
          $display("%0t: y_value mismatch, expected %0d, got %0d", $time, want, y);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  silu_li_in_if  in_if ();
  silu_li_out_if out_if ();
  silu_li_cfg_if cfg_if ();

  silu_lut_interpolator_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  silu_result_tracker tracker = new();

  // Idle percentages for the current phase: sender gaps and receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Main flips hold_token to ask for a long hold-off; the ready process
  // owns the countdown so only one process writes it.
  logic hold_token = 1'b0;
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;
  int   quiet      = 0;
  int   settings   = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic bit coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver: random stalls, or a solid hold-off on request.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= HOLD_LEN;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !coin(stall_pct);
    end
  end

  // Monitors: every accepted beat on the three channels, sampled at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        tracker.take_input(in_if.req_type, in_if.x_value, in_if.entry_index,
                           in_if.entry_value);
      if (out_if.valid && out_if.ready)
        tracker.match_output(out_if.y_value);
      if (cfg_if.valid && cfg_if.ready)
        tracker.set_reg(cfg_if.index, cfg_if.data);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One input beat. Valid stays high across back-to-back beats; it only
  // drops when a random gap falls before this beat.
  task automatic push_item(input logic kind, input silu_li_pkg::sample_t x,
                           input logic [silu_li_pkg::ENTRY_IDX_W-1:0] slot,
                           input silu_li_pkg::sample_t val);
    while (coin(send_idle_pct)) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= kind;
    in_if.x_value     <= x;
    in_if.entry_index <= slot;
    in_if.entry_value <= val;
    @(posedge clk);
    while (!in_if.ready)
      @(posedge clk);
  endtask

  // Both registers in one burst; valid held across the pair.
  task automatic set_regs(input logic [silu_li_pkg::RANGE_W-1:0] range_v,
                          input logic [silu_li_pkg::STEP_W-1:0] step_v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= silu_li_pkg::CFG_X_RANGE;
    cfg_if.data  <= silu_li_pkg::CFG_DATA_W'(range_v);
    @(posedge clk);
    while (!cfg_if.ready)
      @(posedge clk);
    cfg_if.index <= silu_li_pkg::CFG_POS_SCALE;
    cfg_if.data  <= step_v;
    @(posedge clk);
    while (!cfg_if.ready)
      @(posedge clk);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // Drain: the first edge lets the monitor note the last beat, then wait
  // for every expected result, then let trailing loads clear the pipe.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.y_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Mostly evaluates, some loads. Evaluates aim across the whole input span,
  // inside the current range, and right around the clamp points.
  task automatic run_random(input int count);
    int xv;
    int r;
    r = int'(tracker.range_q);
    for (int n = 0; n < count; n++) begin
      if (coin(30)) begin
        push_item(silu_li_pkg::REQ_LOAD, silu_li_pkg::X_W'($urandom),
                  silu_li_pkg::ENTRY_IDX_W'($urandom), silu_li_pkg::X_W'($urandom));
      end else begin
        case ($urandom_range(2))
          0:       xv = int'($urandom_range(65535)) - 32768;
          1:       xv = int'($urandom_range(2 * r)) - r;
          default: xv = (coin(50) ? r : -r) + int'($urandom_range(4)) - 2;
        endcase
        push_item(silu_li_pkg::REQ_EVAL, silu_li_pkg::X_W'(xv),
                  silu_li_pkg::ENTRY_IDX_W'($urandom), silu_li_pkg::X_W'($urandom));
      end
    end
  endtask

  int   probe_x [11] = '{0, -32768, 32767, -16384, 16384, -16385, 16385, -1, 1, 16383, 4096};
  int   edge_x  [4]  = '{32767, 16383, -32768, -16000};
  logic [silu_li_pkg::RANGE_W-1:0] phase_range [6];
  logic [silu_li_pkg::STEP_W-1:0]  phase_step  [6];

  initial begin
    real v;
    in_if.valid       <= 1'b0;
    in_if.req_type    <= silu_li_pkg::REQ_EVAL;
    in_if.x_value     <= '0;
    in_if.entry_index <= '0;
    in_if.entry_value <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= silu_li_pkg::CFG_X_RANGE;
    cfg_if.data       <= '0;
    rst_n             <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, written back explicitly.
    set_regs(silu_li_pkg::X_RANGE_RST, silu_li_pkg::POS_SCALE_RST);

    // Preload a SiLU curve over [-4, +4] so no evaluate ever reads an
    // unwritten slot; later loads only overwrite.
    for (int i = 0; i < silu_li_pkg::LEVELS; i++) begin
      v = -4.0 + 8.0 * i / (silu_li_pkg::LEVELS - 1);
      push_item(silu_li_pkg::REQ_LOAD, silu_li_pkg::X_W'($urandom),
                silu_li_pkg::ENTRY_IDX_W'(i),
                silu_li_pkg::X_W'($rtoi(v / (1.0 + $exp(-v)) * 4096.0)));
    end

    // Directed: field extremes, clamp boundaries, the exact top where the
    // fraction reaches one.
    foreach (probe_x[k])
      push_item(silu_li_pkg::REQ_EVAL, silu_li_pkg::X_W'(probe_x[k]),
                silu_li_pkg::ENTRY_IDX_W'($urandom), silu_li_pkg::X_W'($urandom));
    // Steep extreme segments at both ends of the table to force saturation.
    push_item(silu_li_pkg::REQ_LOAD, silu_li_pkg::X_W'($urandom),
              silu_li_pkg::ENTRY_IDX_W'(255), silu_li_pkg::X_W'(32767));
    push_item(silu_li_pkg::REQ_LOAD, silu_li_pkg::X_W'($urandom),
              silu_li_pkg::ENTRY_IDX_W'(254), silu_li_pkg::X_W'(-32768));
    push_item(silu_li_pkg::REQ_LOAD, silu_li_pkg::X_W'($urandom),
              silu_li_pkg::ENTRY_IDX_W'(0), silu_li_pkg::X_W'(-32768));
    push_item(silu_li_pkg::REQ_LOAD, silu_li_pkg::X_W'($urandom),
              silu_li_pkg::ENTRY_IDX_W'(1), silu_li_pkg::X_W'(32767));
    foreach (edge_x[k])
      push_item(silu_li_pkg::REQ_EVAL, silu_li_pkg::X_W'(edge_x[k]),
                silu_li_pkg::ENTRY_IDX_W'($urandom), silu_li_pkg::X_W'($urandom));
    settle();

    // Settings: nominal, both at maximum (index clamps, extrapolation),
    // zero range, both set to one, a consistent +-2 span, and one random.
    phase_range = '{15'd16384, 15'd32767, 15'd0, 15'd1, 15'd8192, 15'd0};
    phase_step  = '{24'd130560, 24'hFFFFFF, 24'd130560, 24'd1, 24'd261120, 24'd0};
    phase_range[5] = silu_li_pkg::RANGE_W'($urandom_range(32767, 1));
    phase_step[5]  = silu_li_pkg::STEP_W'($urandom_range(24'hFFFFFF, 1));

    for (int p = 0; p < 6; p++) begin
      set_regs(phase_range[p], phase_step[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      // First phase: the receiver holds off while the sender keeps
      // offering, so the pipeline fills and back-pressures the input.
      if (p == 0)
        hold_token <= ~hold_token;
      run_random(PHASE_ITEMS);
      settle();
    end

    $display("Covered %0d table loads and %0d evaluations over %0d register settings,",
             tracker.loads, tracker.evals, settings);
    $display("four idle patterns and a %0d-cycle receiver hold-off; %0d results compared.",
             HOLD_LEN, tracker.checked);
    if (tracker.errors == 0 && tracker.y_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### silu_lut_interpolator_top.f
src/silu_li_pkg.sv
src/silu_li_if.sv
src/silu_li_front.sv
src/silu_li_table.sv
src/silu_li_blend.sv
src/silu_lut_interpolator_top.sv
sim/silu_lut_interpolator_top_test.sv
